// ===== sv/fsrc_pkg.sv =====
// Package with shared types and constants of the foveated shading-rate classifier.
package fsrc_pkg;

  localparam int TILE_W   = 12;
  localparam int CTR_W    = 16;
  localparam int MAG_W    = 16;
  localparam int INV_W    = 32;
  localparam int PROD_W   = MAG_W + INV_W;
  localparam int E_W      = 19;
  localparam int SQP_W    = 2 * E_W;
  localparam int SQ_W     = 21;
  localparam int THR_W    = 17;
  localparam int CLS_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PROD_W-1:0] E_RND   = PROD_W'(2048);
  localparam logic [E_W-1:0]    E_CAP   = E_W'(1 << 18);
  localparam logic [SQP_W-1:0]  SQ_RND  = SQP_W'(32768);
  localparam logic [THR_W-1:0]  SUM_MAX = THR_W'(131071);
  localparam logic [THR_W-1:0]  ONE_Q16 = THR_W'(65536);

  localparam logic [TILE_W-1:0] RST_HALF_WIDTH = TILE_W'(1024);
  localparam logic [INV_W-1:0]  RST_INV_SCALE  = INV_W'(16777216);
  localparam logic [THR_W-1:0]  RST_INNER_SQ   = THR_W'(16384);
  localparam logic [THR_W-1:0]  RST_MID_SQ     = THR_W'(36864);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH   = 3'd0,
    CFG_LEFT_CENTER  = 3'd1,
    CFG_RIGHT_CENTER = 3'd2,
    CFG_INV_SCALE_X  = 3'd3,
    CFG_INV_SCALE_Y  = 3'd4,
    CFG_INNER_SQ     = 3'd5,
    CFG_MID_SQ       = 3'd6
  } cfg_reg_t;

  typedef enum logic [CLS_W-1:0] {
    RATE_FULL   = 2'd0,
    RATE_1X2    = 2'd1,
    RATE_2X2    = 2'd2,
    RATE_4X4    = 2'd3
  } rate_t;

  // Load enables of the three stages inside one axis unit.
  typedef struct packed {
    logic mul;
    logic rnd;
    logic sqr;
  } fsrc_en_t;

endpackage

// ===== sv/foveated_shading_rate_classifier_top.sv =====
// Top level of the foveated shading-rate classifier with its six-stage pipeline.
//
//   Channel   Direction  Word
//   in_*      slave      tile_x [11:0], tile_y [23:12]
//   out_*     master     rate_class [1:0], zero fill [7:2]
//   cfg_*     write      register index, data up to 32 bits
//
// One word enters per cycle while no stall reaches the input; a result is registered in each stage before it leaves.
// The six stages are offset, scale, round and cap, square, sum and compare.
// Reset clears the valid bits and loads the register defaults.
// Every stage carries a valid bit and a stalled output lets empty stages fill.
module foveated_shading_rate_classifier_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [23:0]                          in_tdata,   // tile_x, tile_y
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,  // rate_class
  input  logic                                 cfg_we,
  input  logic [fsrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsrc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int TW = fsrc_pkg::TILE_W;
  localparam int NST = 6;
  localparam logic [TW-1:0] TILE_MASK =
    (COORD_BITS >= TW) ? {TW{1'b1}} : TW'((1 << COORD_BITS) - 1);

  // Configuration registers.
  logic [TW-1:0]                   half_width_r;
  logic [fsrc_pkg::INV_W-1:0]      left_center_r, right_center_r;
  logic [fsrc_pkg::INV_W-1:0]      inv_scale_x_r, inv_scale_y_r;
  logic [fsrc_pkg::THR_W-1:0]      inner_sq_r, mid_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r   <= fsrc_pkg::RST_HALF_WIDTH;
      left_center_r  <= '0;
      right_center_r <= '0;
      inv_scale_x_r  <= fsrc_pkg::RST_INV_SCALE;
      inv_scale_y_r  <= fsrc_pkg::RST_INV_SCALE;
      inner_sq_r     <= fsrc_pkg::RST_INNER_SQ;
      mid_sq_r       <= fsrc_pkg::RST_MID_SQ;
    end else if (cfg_we) begin
      unique case (fsrc_pkg::cfg_reg_t'(cfg_index))
        fsrc_pkg::CFG_HALF_WIDTH:   half_width_r   <= cfg_wdata[TW-1:0];
        fsrc_pkg::CFG_LEFT_CENTER:  left_center_r  <= cfg_wdata;
        fsrc_pkg::CFG_RIGHT_CENTER: right_center_r <= cfg_wdata;
        fsrc_pkg::CFG_INV_SCALE_X:  inv_scale_x_r  <= cfg_wdata;
        fsrc_pkg::CFG_INV_SCALE_Y:  inv_scale_y_r  <= cfg_wdata;
        fsrc_pkg::CFG_INNER_SQ:     inner_sq_r     <= cfg_wdata[fsrc_pkg::THR_W-1:0];
        fsrc_pkg::CFG_MID_SQ:       mid_sq_r       <= cfg_wdata[fsrc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and stage enables; a stage loads when it is empty or its
  // successor loads.
  logic [NST:1] v_r, v_nxt;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v_r[NST] || out_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[1]) begin
      v_nxt[1] = in_tvalid;
    end
    for (int k = 2; k <= NST; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = en[1];

  // Stage 1: pick the eye centre and form the offset magnitudes.
  logic [TW-1:0]                tx, ty;
  logic [fsrc_pkg::INV_W-1:0]   centre;
  logic signed [fsrc_pkg::CTR_W:0] dx, dy;
  logic [fsrc_pkg::CTR_W:0]     ax, ay;
  logic [fsrc_pkg::MAG_W-1:0]   magx_r, magx_nxt, magy_r, magy_nxt;

  always_comb begin
    tx     = in_tdata[TW-1:0] & TILE_MASK;
    ty     = in_tdata[2*TW-1:TW] & TILE_MASK;
    centre = (tx < half_width_r) ? left_center_r : right_center_r;
    dx     = $signed({1'b0, tx, 4'b0000}) - $signed({1'b0, centre[15:0]});
    dy     = $signed({1'b0, ty, 4'b0000}) - $signed({1'b0, centre[31:16]});
    ax     = dx[fsrc_pkg::CTR_W] ? (~dx + (fsrc_pkg::CTR_W+1)'(1)) : dx;
    ay     = dy[fsrc_pkg::CTR_W] ? (~dy + (fsrc_pkg::CTR_W+1)'(1)) : dy;
    magx_nxt = ax[fsrc_pkg::MAG_W-1:0];
    magy_nxt = ay[fsrc_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      magx_r <= magx_nxt;
      magy_r <= magy_nxt;
    end
  end

  // Stages 2 to 4: per-axis scale, round and square.
  fsrc_pkg::fsrc_en_t         axis_en;
  logic [fsrc_pkg::SQ_W-1:0]  sqx, sqy;

  assign axis_en = '{mul: en[2], rnd: en[3], sqr: en[4]};

  fsrc_axis u_axis_x (
    .clk (clk),
    .en  (axis_en),
    .mag (magx_r),
    .inv (inv_scale_x_r),
    .sq  (sqx)
  );

  fsrc_axis u_axis_y (
    .clk (clk),
    .en  (axis_en),
    .mag (magy_r),
    .inv (inv_scale_y_r),
    .sq  (sqy)
  );

  // Stage 5: saturated sums, plain and with one axis quadrupled.
  logic [fsrc_pkg::SQ_W+2:0]  raw_s, raw_a, raw_b;
  logic [fsrc_pkg::THR_W-1:0] sum_r, sum_nxt, a_r, a_nxt, b_r, b_nxt;

  function automatic logic [fsrc_pkg::THR_W-1:0] sat17(input logic [fsrc_pkg::SQ_W+2:0] v);
    logic [fsrc_pkg::THR_W-1:0] res;
    res = (v > (fsrc_pkg::SQ_W+3)'(fsrc_pkg::SUM_MAX)) ? fsrc_pkg::SUM_MAX
                                                      : v[fsrc_pkg::THR_W-1:0];
    return res;
  endfunction

  always_comb begin
    raw_s   = (fsrc_pkg::SQ_W+3)'(sqx) + (fsrc_pkg::SQ_W+3)'(sqy);
    raw_a   = (fsrc_pkg::SQ_W+3)'(sqx) + (fsrc_pkg::SQ_W+3)'({sqy, 2'b00});
    raw_b   = (fsrc_pkg::SQ_W+3)'({sqx, 2'b00}) + (fsrc_pkg::SQ_W+3)'(sqy);
    sum_nxt = sat17(raw_s);
    a_nxt   = sat17(raw_a);
    b_nxt   = sat17(raw_b);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sum_r <= sum_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
    end
  end

  // Stage 6: threshold compares into the output register.
  fsrc_pkg::rate_t cls_r, cls_nxt;

  always_comb begin
    if (sum_r <= inner_sq_r) begin
      cls_nxt = (a_r > inner_sq_r && b_r > inner_sq_r) ? fsrc_pkg::RATE_1X2
                                                       : fsrc_pkg::RATE_FULL;
    end else if (sum_r <= mid_sq_r) begin
      cls_nxt = fsrc_pkg::RATE_1X2;
    end else if (sum_r <= fsrc_pkg::ONE_Q16) begin
      cls_nxt = fsrc_pkg::RATE_2X2;
    end else begin
      cls_nxt = fsrc_pkg::RATE_4X4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_tvalid = v_r[NST];
  assign out_tdata  = {6'b000000, cls_r};

  // An accepted word always lands in the first stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[1])
    else $error("accepted word did not enter stage 1");

  // The input only stalls when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // A blocked stage 5 keeps its word.
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && !en[5]) |=> (v_r[5] && $stable(sum_r)))
    else $error("blocked stage lost its word");

  // A sum beyond 1.0 and beyond both factors is always the coarsest rate.
  a_coarse: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && en[6] && sum_r > fsrc_pkg::ONE_Q16 && sum_r > inner_sq_r
     && sum_r > mid_sq_r) |=> (cls_r == fsrc_pkg::RATE_4X4))
    else $error("large sum not classified as coarsest");

endmodule

// ===== sv/fsrc_axis.sv =====
// One axis of the classifier: scale, round and cap, then square in Q.16.
module fsrc_axis (
  input  logic                           clk,
  input  fsrc_pkg::fsrc_en_t             en,
  input  logic [fsrc_pkg::MAG_W-1:0]     mag,
  input  logic [fsrc_pkg::INV_W-1:0]     inv,
  output logic [fsrc_pkg::SQ_W-1:0]      sq
);

  logic [fsrc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [fsrc_pkg::E_W-1:0]    e_r, e_nxt;
  logic [fsrc_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [fsrc_pkg::PROD_W-1:0] rnd_sum;
  logic [fsrc_pkg::PROD_W-13:0] e_full;
  logic [fsrc_pkg::SQP_W-1:0]  sq_full;

  always_comb begin
    prod_nxt = fsrc_pkg::PROD_W'(mag) * fsrc_pkg::PROD_W'(inv);
    rnd_sum  = prod_r + fsrc_pkg::E_RND;
    e_full   = rnd_sum[fsrc_pkg::PROD_W-1:12];
    if (e_full > (fsrc_pkg::PROD_W-12)'(fsrc_pkg::E_CAP)) begin
      e_nxt = fsrc_pkg::E_CAP;
    end else begin
      e_nxt = e_full[fsrc_pkg::E_W-1:0];
    end
    sq_full = fsrc_pkg::SQP_W'(e_r) * fsrc_pkg::SQP_W'(e_r) + fsrc_pkg::SQ_RND;
    sq_nxt  = sq_full[fsrc_pkg::SQ_W+15:16];
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
    if (en.rnd) begin
      e_r <= e_nxt;
    end
    if (en.sqr) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

// ===== tb/foveated_shading_rate_classifier_top_tb.sv =====
// Self-checking testbench that predicts and checks the rate class of every tile word.
module foveated_shading_rate_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int RAND_PHASES = 8;
  localparam int WORDS_PER_PHASE = 170;
  localparam int PRESSURE_WORDS = 120;
  localparam int MAX_REPORTS = 10;
  localparam logic [fsrc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [fsrc_pkg::TILE_W-1:0] y;
    logic [fsrc_pkg::TILE_W-1:0] x;
  } tile_word_t;

  typedef struct {
    tile_word_t tile;
    fsrc_pkg::rate_t rate;
  } rate_entry_t;

  typedef struct {
    logic [fsrc_pkg::TILE_W-1:0] half_width;
    logic [31:0] left_center;
    logic [31:0] right_center;
    logic [fsrc_pkg::INV_W-1:0] inv_x;
    logic [fsrc_pkg::INV_W-1:0] inv_y;
    logic [fsrc_pkg::THR_W-1:0] inner_sq;
    logic [fsrc_pkg::THR_W-1:0] mid_sq;
  } setting_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [fsrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fsrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  setting_t shadow = '{fsrc_pkg::RST_HALF_WIDTH, 32'd0, 32'd0,
                       fsrc_pkg::RST_INV_SCALE, fsrc_pkg::RST_INV_SCALE,
                       fsrc_pkg::RST_INNER_SQ, fsrc_pkg::RST_MID_SQ};
  tile_word_t tiles_waiting[$];
  rate_entry_t rate_due[$];
  bit in_busy = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;
  int failures = 0;
  int cycles = 0;
  int rad_x = 64;
  int rad_y = 64;

  foveated_shading_rate_classifier_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] axis_sq(logic [fsrc_pkg::TILE_W-1:0] t,
                                          logic [fsrc_pkg::CTR_W-1:0] c,
                                          logic [fsrc_pkg::INV_W-1:0] inv);
    logic signed [17:0] d;
    logic [fsrc_pkg::MAG_W-1:0] mag;
    logic [63:0] e;
    d = $signed({2'b00, t, 4'b0000}) - $signed({2'b00, c});
    mag = (d < 0) ? fsrc_pkg::MAG_W'(-d) : fsrc_pkg::MAG_W'(d);
    e = (64'(mag) * 64'(inv) + 64'd2048) >> 12;
    if (e > 64'(fsrc_pkg::E_CAP)) e = 64'(fsrc_pkg::E_CAP);
    return (e * e + 64'd32768) >> 16;
  endfunction

  function automatic logic [fsrc_pkg::THR_W-1:0] clip_sum(logic [63:0] s);
    return (s > 64'(fsrc_pkg::SUM_MAX)) ? fsrc_pkg::SUM_MAX : s[fsrc_pkg::THR_W-1:0];
  endfunction

  function automatic fsrc_pkg::rate_t classify_tile(tile_word_t w);
    logic [31:0] ctr;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [fsrc_pkg::THR_W-1:0] sum;
    fsrc_pkg::rate_t r;
    ctr = (w.x < shadow.half_width) ? shadow.left_center : shadow.right_center;
    sqx = axis_sq(w.x, ctr[15:0], shadow.inv_x);
    sqy = axis_sq(w.y, ctr[31:16], shadow.inv_y);
    sum = clip_sum(sqx + sqy);
    if (sum <= shadow.inner_sq) r = fsrc_pkg::RATE_FULL;
    else if (sum <= shadow.mid_sq) r = fsrc_pkg::RATE_1X2;
    else if (sum <= fsrc_pkg::ONE_Q16) r = fsrc_pkg::RATE_2X2;
    else r = fsrc_pkg::RATE_4X4;
    if (r == fsrc_pkg::RATE_FULL && clip_sum(sqx + 4 * sqy) > shadow.inner_sq &&
        clip_sum(4 * sqx + sqy) > shadow.inner_sq) r = fsrc_pkg::RATE_1X2;
    return r;
  endfunction

  function automatic void shadow_write(logic [fsrc_pkg::CFG_IDX_W-1:0] idx,
                                       logic [fsrc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      fsrc_pkg::CFG_HALF_WIDTH: shadow.half_width = val[fsrc_pkg::TILE_W-1:0];
      fsrc_pkg::CFG_LEFT_CENTER: shadow.left_center = val;
      fsrc_pkg::CFG_RIGHT_CENTER: shadow.right_center = val;
      fsrc_pkg::CFG_INV_SCALE_X: shadow.inv_x = val;
      fsrc_pkg::CFG_INV_SCALE_Y: shadow.inv_y = val;
      fsrc_pkg::CFG_INNER_SQ: shadow.inner_sq = val[fsrc_pkg::THR_W-1:0];
      fsrc_pkg::CFG_MID_SQ: shadow.mid_sq = val[fsrc_pkg::THR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void log_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  task automatic write_reg(logic [fsrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fsrc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic queue_tile(int x, int y);
    tile_word_t w;
    w.x = fsrc_pkg::TILE_W'(x);
    w.y = fsrc_pkg::TILE_W'(y);
    tiles_waiting.push_back(w);
  endtask

  task automatic drain();
    while (tiles_waiting.size() != 0 || rate_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] eye_center(int lo, int hi);
    return {fsrc_pkg::CTR_W'($urandom_range(0, 2047) * 16 + $urandom_range(0, 15)),
            fsrc_pkg::CTR_W'($urandom_range(lo, hi) * 16 + $urandom_range(0, 15))};
  endfunction

  task automatic pick_setting();
    int hw;
    logic [31:0] lc;
    logic [31:0] rc;
    logic [fsrc_pkg::INV_W-1:0] ix;
    logic [fsrc_pkg::INV_W-1:0] iy;
    logic [fsrc_pkg::THR_W-1:0] inner;
    logic [fsrc_pkg::THR_W-1:0] mid;
    hw = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 4095)
                                      : $urandom_range(300, 3500);
    lc = eye_center(0, (hw > 0) ? hw - 1 : 0);
    rc = eye_center(hw, 4095);
    if ($urandom_range(0, 9) == 0) lc = 32'hFFFF_FFFF;
    if ($urandom_range(0, 9) == 0) rc = 32'd0;
    rad_x = $urandom_range(2, 300);
    rad_y = $urandom_range(2, 300);
    ix = (32'd1 << 24) / rad_x;
    iy = (32'd1 << 24) / rad_y;
    if ($urandom_range(0, 7) == 0) ix = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
    if ($urandom_range(0, 7) == 0) iy = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
    case ($urandom_range(0, 7))
      0: inner = 17'd0;
      1: inner = fsrc_pkg::ONE_Q16;
      2: inner = fsrc_pkg::SUM_MAX;
      default: inner = fsrc_pkg::THR_W'($urandom_range(4000, 40000));
    endcase
    case ($urandom_range(0, 7))
      0: mid = 17'd0;
      1: mid = fsrc_pkg::SUM_MAX;
      2: mid = fsrc_pkg::THR_W'($urandom_range(0, 131071));
      default: mid = fsrc_pkg::THR_W'($urandom_range(20000, 65536));
    endcase
    write_reg(fsrc_pkg::CFG_HALF_WIDTH, fsrc_pkg::CFG_DATA_W'(hw));
    write_reg(fsrc_pkg::CFG_LEFT_CENTER, lc);
    write_reg(fsrc_pkg::CFG_RIGHT_CENTER, rc);
    write_reg(fsrc_pkg::CFG_INV_SCALE_X, ix);
    write_reg(fsrc_pkg::CFG_INV_SCALE_Y, iy);
    write_reg(fsrc_pkg::CFG_INNER_SQ, fsrc_pkg::CFG_DATA_W'(inner));
    write_reg(fsrc_pkg::CFG_MID_SQ, fsrc_pkg::CFG_DATA_W'(mid));
  endtask

  function automatic int clamp_tile(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  task automatic queue_random_tile();
    logic [31:0] ctr;
    int sx;
    int sy;
    if ($urandom_range(0, 3) == 0) begin
      queue_tile($urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      ctr = ($urandom_range(0, 1) == 0) ? shadow.left_center : shadow.right_center;
      sx = 3 * rad_x;
      sy = 3 * rad_y;
      queue_tile(clamp_tile(int'(ctr[15:4]) + int'($urandom_range(0, sx)) - sx / 2),
                 clamp_tile(int'(ctr[31:20]) + int'($urandom_range(0, sy)) - sy / 2));
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && !in_busy) begin
      if (tiles_waiting.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= tiles_waiting[0];
        in_busy = 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    rate_entry_t entry;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        entry.tile = tile_word_t'(in_tdata);
        entry.rate = classify_tile(entry.tile);
        rate_due.push_back(entry);
        void'(tiles_waiting.pop_front());
        in_busy = 1'b0;
      end
      if (out_tvalid && out_tready) begin
        if (rate_due.size() == 0) begin
          log_failure($sformatf("unexpected word, rate_class %0d",
                                out_tdata[fsrc_pkg::CLS_W-1:0]));
        end else begin
          entry = rate_due.pop_front();
          if (out_tdata[fsrc_pkg::CLS_W-1:0] !== entry.rate)
            log_failure($sformatf("tile x=%0d y=%0d: rate_class expected %0d, got %0d",
                                  entry.tile.x, entry.tile.y, entry.rate,
                                  out_tdata[fsrc_pkg::CLS_W-1:0]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL foveated_shading_rate_classifier_top");
      $finish;
    end
  end

  initial begin : run
    int ph;
    int i;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults, corners of the map and both sides of the half width.
    queue_tile(0, 0);
    queue_tile(4095, 4095);
    queue_tile(0, 4095);
    queue_tile(4095, 0);
    queue_tile(1023, 0);
    queue_tile(1024, 0);
    drain();

    // Huge offsets hit the cap and saturate the sum, which still passes a full-scale
    // inner threshold. The write to the unused index must change nothing.
    write_reg(fsrc_pkg::CFG_HALF_WIDTH, 32'd0);
    write_reg(fsrc_pkg::CFG_LEFT_CENTER, 32'h1234_5678);
    write_reg(fsrc_pkg::CFG_RIGHT_CENTER, 32'hFFFF_FFFF);
    write_reg(fsrc_pkg::CFG_INV_SCALE_X, 32'hFFFF_FFFF);
    write_reg(fsrc_pkg::CFG_INV_SCALE_Y, 32'd0);
    write_reg(fsrc_pkg::CFG_INNER_SQ, 32'(fsrc_pkg::SUM_MAX));
    write_reg(fsrc_pkg::CFG_MID_SQ, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_tile(0, 0);
    queue_tile(4095, 4095);
    queue_tile(2048, 1);
    drain();

    // Middle factor below the inner one, and class 0 kept or demoted by the axis tests.
    write_reg(fsrc_pkg::CFG_HALF_WIDTH, 32'd4095);
    write_reg(fsrc_pkg::CFG_LEFT_CENTER, {16'd640, 16'd800});
    write_reg(fsrc_pkg::CFG_RIGHT_CENTER, 32'd0);
    write_reg(fsrc_pkg::CFG_INV_SCALE_X, 32'd1048576);
    write_reg(fsrc_pkg::CFG_INV_SCALE_Y, 32'd1048576);
    write_reg(fsrc_pkg::CFG_INNER_SQ, 32'd40000);
    write_reg(fsrc_pkg::CFG_MID_SQ, 32'd20000);
    queue_tile(50, 40);
    queue_tile(55, 45);
    queue_tile(58, 48);
    queue_tile(60, 40);
    queue_tile(62, 40);
    queue_tile(63, 40);
    queue_tile(66, 40);
    queue_tile(67, 40);
    queue_tile(4095, 4095);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      pick_setting();
      for (i = 0; i < WORDS_PER_PHASE; i++) queue_random_tile();
      drain();
    end

    // The receiver holds off while the sender keeps offering words.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pick_setting();
    for (i = 0; i < PRESSURE_WORDS; i++) queue_random_tile();
    hold_req++;
    drain();

    if (failures == 0 && rate_due.size() == 0) begin
      $display("PASS foveated_shading_rate_classifier_top");
    end else begin
      $display("FAIL foveated_shading_rate_classifier_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fsrc_pkg.sv
sv/fsrc_axis.sv
sv/foveated_shading_rate_classifier_top.sv
tb/foveated_shading_rate_classifier_top_tb.sv
